// ===== rtl/core/scmb_pkg.sv =====
// Package: constants, types and helpers shared by the colour map blend block.
package scmb_pkg;

  localparam int unsigned AxisPoints = 1024;
  localparam int unsigned MaxStops   = 8;
  localparam int unsigned Pairs      = 4;
  localparam int unsigned PointW     = 10;
  localparam int unsigned StopW      = 3;
  localparam int unsigned PairW      = 2;
  localparam int unsigned PalAddrW   = PairW + StopW;
  localparam int unsigned PalDepth   = Pairs * MaxStops;

  localparam logic [15:0] LastStopQ16 = 16'd65471;
  localparam logic [15:0] FullColour  = 16'hFFFF;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpBlend = 2'd1,
    OpEmit  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  pair;
    logic [2:0]  stop_index;
    logic [15:0] stop_ratio;
    logic [7:0]  stop_red;
    logic [7:0]  stop_green;
    logic [7:0]  stop_blue;
    logic [9:0]  point;
    logic [16:0] intensity;
  } req_t;

  typedef struct packed {
    logic [9:0] out_point;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rsp_t;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } rgb_t;

  // Accumulated colour to byte: floor(v / 257) for 16-bit v.
  function automatic logic [7:0] to_byte(logic [15:0] v);
    logic [31:0] p;
    logic [7:0]  q;
    logic [16:0] rem;
    p   = 32'(v) * 32'd255;
    q   = p[23:16];
    rem = 17'(v) - 17'(q) * 17'd257;
    if (rem >= 17'd257) q = q + 8'd1;
    return q;
  endfunction

endpackage

// ===== rtl/core/scmb_if.sv =====
// Interfaces: valid/ready request, response and config channels of the block.
interface scmb_req_if;
  import scmb_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scmb_rsp_if;
  import scmb_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scmb_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/scmb_div.sv =====
// Divider: radix-2 restoring divide of a 32-bit dividend by a 16-bit divisor.
module scmb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);
  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  // The quotient never exceeds 17 bits since the dividend is below den << 17.
  always_comb begin
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; quo_d = '0;
      cnt_d = 5'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[31]} - {2'b00, den_q};
      num_d = {num_q[30:0], 1'b0};
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], num_q[31]};
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/scmb_acc_mem.sv =====
// Accumulator store: one 48-bit RGB entry per axis point, registered read.
module scmb_acc_mem (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [scmb_pkg::PointW-1:0] waddr_i,
  input  scmb_pkg::rgb_t         wdata_i,
  input  logic [scmb_pkg::PointW-1:0] raddr_i,
  output scmb_pkg::rgb_t         rdata_o
);
  import scmb_pkg::*;
  rgb_t mem [AxisPoints];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/core/spectrum_colour_map_blend.sv =====
// Top level: gradient colour map with screen blend into a per-point store.
//
//  channel  | dir | carries
//  req_*    | in  | op, pair, stop, colour, point, intensity
//  rsp_*    | out | out_point, RGBA bytes
//  cfg_*    | in  | stops_in_use
//
// A load is written when it is taken; an emit waits for the output register.
// A blend at or above the last-stop threshold goes from the stop walk straight
// to multiply and write back; otherwise it walks the stops (a blend that reaches
// no stop ends there), starts the divider, runs the serial divider (skipped for a
// zero ratio), then mixes, multiplies and writes back.
// After reset a clearing pass sweeps the 1024-entry accumulator store, one
// entry a cycle; no request is taken meanwhile, config writes always are.
// A full output register stalls emits only; a request is taken when idle.
module spectrum_colour_map_blend (
  input  logic         clk_i,
  input  logic         rst_ni,
  scmb_req_if.sink     req,
  scmb_rsp_if.source   rsp,
  scmb_cfg_if.sink     cfg
);
  import scmb_pkg::*;

  typedef enum logic [9:0] {
    StClear = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StWalk  = 10'b0000000100,
    StPal   = 10'b0000001000,
    StDiv   = 10'b0000010000,
    StMix   = 10'b0000100000,
    StMul   = 10'b0001000000,
    StAdd   = 10'b0010000000,
    StEmit  = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic [3:0] stops_q;

  // Small tables: ratios and palettes live in flops, reset to zero.
  logic [15:0] ratio_q [MaxStops];
  rgb_t        pal_q   [PalDepth];

  logic [PointW-1:0] clr_q;
  logic [2:0]  idx_q;
  logic [16:0] sum_q;
  logic [15:0] r_q;
  logic [16:0] mix_q;
  rgb_t        lo_q, hi_q, col_q, acc_q;
  logic [31:0] prod_q [3];
  rsp_t        rsp_q;
  logic        rsp_v_q;

  logic [2:0]  n_stops;
  logic [16:0] sum_n;
  logic        div_start, div_done;
  logic [16:0] div_quo;
  logic        mem_we;
  logic [PointW-1:0] mem_waddr;
  logic [PointW-1:0] mem_raddr;
  rgb_t        mem_wdata, mem_rdata;

  // Saturate the stop count into [2, MaxStops]; stored minus one as last stop.
  always_comb begin
    if (stops_q < 4'd2)      n_stops = 3'd1;
    else if (stops_q > 4'd8) n_stops = 3'd7;
    else                     n_stops = 3'(stops_q - 4'd1);
  end

  assign sum_n = sum_q + 17'(ratio_q[idx_q]);

  scmb_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  ({16'(req_q.intensity[15:0] - sum_q[15:0] + r_q), 16'h0}),
    .den_i  (r_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Read the incoming point while idle, then hold the accepted point's entry.
  assign mem_raddr = (state_q == StIdle) ? req.data.point : req_q.point;

  scmb_acc_mem u_mem (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign req.ready = (state_q == StIdle);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  logic take;
  assign take = req.valid && req.ready;

  // Screen blend of one channel: acc + (65535-acc)*c/65535, via
  // x/65535 = (x + (x >> 16) + 1) >> 16 for x < 2^32.
  function automatic logic [15:0] scr(logic [15:0] a, logic [31:0] p);
    logic [32:0] t;
    logic [16:0] s;
    t = 33'(p) + 33'(p[31:16]) + 33'd1;
    s = 17'(a) + 17'(t[32:16]);
    return (s > 17'(FullColour)) ? FullColour : s[15:0];
  endfunction

  function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b,
                                       logic [16:0] m);
    logic [33:0] t;
    t = 34'(a) * 34'(17'h10000 - m) + 34'(b) * 34'(m);
    return t[31:16];
  endfunction

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = req_q.point;
    mem_wdata = '0;
    unique case (state_q)
      StClear: begin
        mem_we = 1'b1; mem_waddr = clr_q;
        if (clr_q == PointW'(AxisPoints - 1)) state_d = StIdle;
      end
      StIdle: if (take) begin
        unique case (op_e'(req.data.op))
          OpBlend: if (!req.data.intensity[16] && 32'(req.data.pair) < Pairs)
                     state_d = StWalk;
          OpEmit:  state_d = StEmit;
          default: state_d = StIdle;
        endcase
      end
      StWalk: begin
        if (req_q.intensity[15:0] >= LastStopQ16) state_d = StMul;
        else if (sum_n >= 17'(req_q.intensity)) state_d = StPal;
        else if (idx_q == n_stops) state_d = StIdle;
      end
      StPal: begin
        if (r_q == 16'd0) state_d = StMix;
        else begin div_start = 1'b1; state_d = StDiv; end
      end
      StDiv: if (div_done) state_d = StMix;
      StMix: state_d = StMul;
      StMul: state_d = StAdd;
      StAdd: begin
        mem_we = 1'b1;
        mem_wdata.r = scr(acc_q.r, prod_q[0]);
        mem_wdata.g = scr(acc_q.g, prod_q[1]);
        mem_wdata.b = scr(acc_q.b, prod_q[2]);
        state_d = StIdle;
      end
      StEmit: if (!rsp_v_q) begin
        mem_we = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      stops_q <= 4'd8;
      rsp_v_q <= 1'b0;
      for (int i = 0; i < MaxStops; i++) ratio_q[i] <= '0;
      for (int i = 0; i < PalDepth; i++) pal_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + PointW'(1);
      if (cfg.valid) stops_q <= cfg.data;
      if (rsp.valid && rsp.ready) rsp_v_q <= 1'b0;
      if (state_q == StEmit && !rsp_v_q) rsp_v_q <= 1'b1;
      if (take && op_e'(req.data.op) == OpLoad && 32'(req.data.pair) < Pairs) begin
        ratio_q[req.data.stop_index] <= req.data.stop_ratio;
        pal_q[{req.data.pair, req.data.stop_index}] <= '{
          r: {req.data.stop_red, req.data.stop_red},
          g: {req.data.stop_green, req.data.stop_green},
          b: {req.data.stop_blue, req.data.stop_blue}};
      end
    end
  end

  // Datapath registers hold payload only.
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req.data;
      idx_q <= 3'd1;
      sum_q <= '0;
    end
    // Capture the stored colour during the walk; the read address holds the point.
    if (state_q == StWalk) acc_q <= mem_rdata;
    if (state_q == StWalk) begin
      if (req_q.intensity[15:0] >= LastStopQ16) begin
        col_q <= pal_q[{req_q.pair, n_stops}];
      end else begin
        sum_q <= sum_n;
        r_q   <= ratio_q[idx_q];
        if (sum_n < 17'(req_q.intensity)) idx_q <= idx_q + 3'd1;
      end
    end
    if (state_q == StPal) begin
      lo_q  <= pal_q[{req_q.pair, 3'(idx_q - 3'd1)}];
      hi_q  <= pal_q[{req_q.pair, idx_q}];
      mix_q <= '0;
    end
    if (state_q == StDiv && div_done)
      mix_q <= (div_quo > 17'h10000) ? 17'h10000 : div_quo;
    if (state_q == StMix) begin
      col_q.r <= lerp(lo_q.r, hi_q.r, mix_q);
      col_q.g <= lerp(lo_q.g, hi_q.g, mix_q);
      col_q.b <= lerp(lo_q.b, hi_q.b, mix_q);
    end
    if (state_q == StMul) begin
      prod_q[0] <= 32'(FullColour - acc_q.r) * 32'(col_q.r);
      prod_q[1] <= 32'(FullColour - acc_q.g) * 32'(col_q.g);
      prod_q[2] <= 32'(FullColour - acc_q.b) * 32'(col_q.b);
    end
    if (state_q == StEmit && !rsp_v_q) begin
      rsp_q.out_point <= req_q.point;
      rsp_q.red       <= to_byte(mem_rdata.r);
      rsp_q.green     <= to_byte(mem_rdata.g);
      rsp_q.blue      <= to_byte(mem_rdata.b);
      rsp_q.alpha     <= 8'hFF;
    end
  end
endmodule
